[rtl/core/scs_pkg.sv]
package scs_pkg;

  localparam int unsigned ReadyLimitWidth = 10;
  localparam int unsigned RespLimitWidth  = 8;
  localparam int unsigned PollWidth       = 10;
  localparam int unsigned CfgIndexWidth   = 2;
  localparam int unsigned CfgDataWidth    = 10;
  localparam int unsigned InDataWidth     = 56;
  localparam int unsigned OutDataWidth    = 24;

  localparam logic [ReadyLimitWidth-1:0] ReadyLimitReset = 10'd1000;
  localparam logic [RespLimitWidth-1:0]  RespLimitReset  = 8'd10;

  localparam logic [7:0] FillByte  = 8'hFF;
  localparam logic [7:0] StartBits = 8'h40;

  localparam logic [2:0] FrameLast = 3'd5;

  localparam logic OpStart = 1'b0;
  localparam logic OpRx    = 1'b1;

  localparam logic [CfgIndexWidth-1:0] RegReadyLimit = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegRespLimit  = 2'd1;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_DESEL = 6'b000010,
    PH_READY = 6'b000100,
    PH_FRAME = 6'b001000,
    PH_RESP  = 6'b010000,
    PH_TOUT  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       timed_out;
    logic [7:0] response;
    logic       done_res;
    logic       select_high;
    logic [7:0] tx_byte;
    logic       transfer_valid;
  } result_t;

  typedef struct packed {
    logic        operation;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [7:0]  crc_byte;
    logic [7:0]  rx_byte;
  } item_t;

  function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [5:0] cmd,
                                            input logic [31:0] arg, input logic [7:0] crc);
    logic [7:0] b;
    case (idx)
      3'd0:    b = StartBits | {2'b00, cmd};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

  function automatic result_t make_result(input logic xfer, input logic [7:0] tx,
                                          input logic csh, input logic done,
                                          input logic [7:0] resp, input logic tout);
    result_t r;
    r.transfer_valid = xfer;
    r.tx_byte        = tx;
    r.select_high    = csh;
    r.done_res       = done;
    r.response       = resp;
    r.timed_out      = tout;
    return r;
  endfunction

endpackage

[rtl/core/scs_core.sv]
module scs_core import scs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  item_t                      item,
  input  logic [ReadyLimitWidth-1:0] ready_poll_limit,
  input  logic [RespLimitWidth-1:0]  response_poll_limit,
  output result_t                    result
);

  phase_t                phase, phase_next;
  logic [PollWidth-1:0]  poll_count, poll_count_next;
  logic [2:0]            frame_index, frame_index_next;
  logic [5:0]            held_command;
  logic [31:0]           held_argument;
  logic [7:0]            held_crc;
  logic [PollWidth-1:0]  poll_inc;
  logic [2:0]            frame_inc;

  assign poll_inc  = poll_count + PollWidth'(1);
  assign frame_inc = frame_index + 3'd1;

  always_comb begin
    phase_next       = phase;
    poll_count_next  = poll_count;
    frame_index_next = frame_index;
    result           = make_result(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    if (item.operation == OpStart) begin
      phase_next       = PH_DESEL;
      poll_count_next  = '0;
      frame_index_next = '0;
      result           = make_result(1'b1, FillByte, 1'b1, 1'b0, 8'h00, 1'b0);
    end else begin
      case (phase)
        PH_DESEL: begin
          poll_count_next = '0;
          phase_next      = PH_READY;
          result          = make_result(1'b1, FillByte, 1'b0, 1'b0, 8'h00, 1'b0);
        end
        PH_READY: begin
          poll_count_next = poll_inc;
          if (item.rx_byte == FillByte) begin
            frame_index_next = '0;
            phase_next       = PH_FRAME;
            result = make_result(1'b1, frame_byte(3'd0, held_command, held_argument, held_crc),
                                 1'b0, 1'b0, 8'h00, 1'b0);
          end else if (poll_inc >= ready_poll_limit) begin
            phase_next = PH_TOUT;
            result     = make_result(1'b1, FillByte, 1'b1, 1'b0, 8'h00, 1'b0);
          end else begin
            result = make_result(1'b1, FillByte, 1'b0, 1'b0, 8'h00, 1'b0);
          end
        end
        PH_FRAME: begin
          if (frame_index >= FrameLast) begin
            frame_index_next = '0;
            poll_count_next  = '0;
            phase_next       = PH_RESP;
            result = make_result(1'b1, FillByte, 1'b0, 1'b0, 8'h00, 1'b0);
          end else begin
            frame_index_next = frame_inc;
            result = make_result(1'b1, frame_byte(frame_inc, held_command, held_argument,
                                                  held_crc), 1'b0, 1'b0, 8'h00, 1'b0);
          end
        end
        PH_RESP: begin
          poll_count_next = poll_inc;
          if (!item.rx_byte[7] ||
              poll_inc >= {{(PollWidth-RespLimitWidth){1'b0}}, response_poll_limit}) begin
            phase_next = PH_IDLE;
            result     = make_result(1'b0, 8'h00, 1'b0, 1'b1, item.rx_byte, 1'b0);
          end else begin
            result = make_result(1'b1, FillByte, 1'b0, 1'b0, 8'h00, 1'b0);
          end
        end
        PH_TOUT: begin
          phase_next = PH_IDLE;
          result     = make_result(1'b0, 8'h00, 1'b1, 1'b1, FillByte, 1'b1);
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      poll_count  <= '0;
      frame_index <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      poll_count  <= poll_count_next;
      frame_index <= frame_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.operation == OpStart) begin
      held_command  <= item.command_index;
      held_argument <= item.argument;
      held_crc      <= item.crc_byte;
    end
  end

endmodule

[rtl/core/scs_out_reg.sv]
module scs_out_reg import scs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_data <= load_data;
    end
  end

endmodule

[rtl/core/sd_spi_command_sequencer.sv]
// SD card SPI-mode command sequencer for R1 commands. A start item (tuser 0) latches the
// command, argument and CRC; every later item (tuser 1) carries the byte the card returned
// during the previously requested exchange and yields one result: the next byte to send
// and its chip select level, or the finished R1 response (0xFF with timed_out on a
// card-ready timeout). One item is taken per clock while the single output register is
// empty or being read; each result lands there in the cycle after its transfer. Users must
// write poll limits over the cfg port only while no command is in flight (not enforced).
module sd_spi_command_sequencer import scs_pkg::*; #(
  parameter logic [ReadyLimitWidth-1:0] READY_LIMIT_RESET = ReadyLimitReset,
  parameter logic [RespLimitWidth-1:0]  RESP_LIMIT_RESET  = RespLimitReset
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // command_index[5:0], argument[37:6], crc_byte[45:38], rx_byte[53:46], zero pad
  input  logic [InDataWidth-1:0]   s_axis_tdata,
  // operation[0]
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // transfer_valid[0], tx_byte[8:1], select_high[9], done_res[10], response[18:11],
  // timed_out[19], zero pad
  output logic [OutDataWidth-1:0]  m_axis_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  logic [ReadyLimitWidth-1:0] ready_poll_limit;
  logic [RespLimitWidth-1:0]  response_poll_limit;
  item_t                      item;
  result_t                    result;
  result_t                    out_data;
  logic                       can_load;
  logic                       accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_poll_limit    <= READY_LIMIT_RESET;
      response_poll_limit <= RESP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == RegReadyLimit) begin
        ready_poll_limit <= cfg_data[ReadyLimitWidth-1:0];
      end
      if (cfg_index == RegRespLimit) begin
        response_poll_limit <= cfg_data[RespLimitWidth-1:0];
      end
    end
  end

  assign item.operation     = s_axis_tuser;
  assign item.command_index = s_axis_tdata[5:0];
  assign item.argument      = s_axis_tdata[37:6];
  assign item.crc_byte      = s_axis_tdata[45:38];
  assign item.rx_byte       = s_axis_tdata[53:46];

  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  scs_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .accept              (accept),
    .item                (item),
    .ready_poll_limit    (ready_poll_limit),
    .response_poll_limit (response_poll_limit),
    .result              (result)
  );

  scs_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s_axis_tvalid),
    .load_data (result),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {{(OutDataWidth - $bits(result_t)){1'b0}}, out_data};

endmodule

[tb/tb_sd_spi_command_sequencer.sv]
module tb_sd_spi_command_sequencer import scs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned PhaseItems  = 75;
  localparam int unsigned ResultWidth = $bits(result_t);

  // tracks the command sequencer and owes one result per accepted item
  class r1_exchange_tracker;
    logic [ReadyLimitWidth-1:0] ready_limit;
    logic [RespLimitWidth-1:0]  resp_limit;
    phase_t                     phase;
    logic [PollWidth-1:0]       polls;
    logic [2:0]                 frame_pos;
    logic [5:0]                 held_cmd;
    logic [31:0]                held_arg;
    logic [7:0]                 held_crc;
    result_t                    owed_results[$];
    int unsigned                mismatches;
    int unsigned                checked;

    function new();
      ready_limit = ReadyLimitReset;
      resp_limit  = RespLimitReset;
      phase       = PH_IDLE;
      polls       = '0;
      frame_pos   = '0;
      held_cmd    = '0;
      held_arg    = '0;
      held_crc    = '0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void note_config(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
      if (idx == RegReadyLimit) begin
        ready_limit = val[ReadyLimitWidth-1:0];
      end else if (idx == RegRespLimit) begin
        resp_limit = val[RespLimitWidth-1:0];
      end
    endfunction

    function logic [7:0] frame_byte_at(logic [2:0] pos);
      if (pos == 3'd0) return StartBits | {2'b00, held_cmd};
      if (pos < FrameLast) return held_arg[8*(4-pos) +: 8];
      return held_crc;
    endfunction

    function result_t next_exchange(item_t it);
      result_t r;
      r = '0;
      if (it.operation == OpStart) begin
        held_cmd  = it.command_index;
        held_arg  = it.argument;
        held_crc  = it.crc_byte;
        polls     = '0;
        frame_pos = '0;
        phase     = PH_DESEL;
        r.transfer_valid = 1'b1;
        r.tx_byte        = FillByte;
        r.select_high    = 1'b1;
        return r;
      end
      case (phase)
        PH_DESEL: begin
          polls = '0;
          phase = PH_READY;
          r.transfer_valid = 1'b1;
          r.tx_byte        = FillByte;
        end
        PH_READY: begin
          polls = polls + 1'b1;
          r.transfer_valid = 1'b1;
          r.tx_byte        = FillByte;
          if (it.rx_byte == FillByte) begin
            frame_pos = '0;
            phase     = PH_FRAME;
            r.tx_byte = frame_byte_at(3'd0);
          end else if (polls >= ready_limit) begin
            phase         = PH_TOUT;
            r.select_high = 1'b1;
          end
        end
        PH_FRAME: begin
          r.transfer_valid = 1'b1;
          if (frame_pos >= FrameLast) begin
            frame_pos = '0;
            polls     = '0;
            phase     = PH_RESP;
            r.tx_byte = FillByte;
          end else begin
            frame_pos = frame_pos + 1'b1;
            r.tx_byte = frame_byte_at(frame_pos);
          end
        end
        PH_RESP: begin
          polls = polls + 1'b1;
          if (!it.rx_byte[7] || polls >= {2'b00, resp_limit}) begin
            phase      = PH_IDLE;
            r.done_res = 1'b1;
            r.response = it.rx_byte;
          end else begin
            r.transfer_valid = 1'b1;
            r.tx_byte        = FillByte;
          end
        end
        PH_TOUT: begin
          phase         = PH_IDLE;
          r.select_high = 1'b1;
          r.done_res    = 1'b1;
          r.response    = FillByte;
          r.timed_out   = 1'b1;
        end
        default: phase = PH_IDLE;
      endcase
      return r;
    endfunction

    function void note_item(item_t it);
      owed_results.push_back(next_exchange(it));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("[%0t] result %0d %0s: got %0h want %0h", $realtime, checked, what, got, want);
    endtask

    task check_result(logic [OutDataWidth-1:0] data);
      result_t got;
      result_t want;
      got = data[ResultWidth-1:0];
      checked++;
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result", data, '0);
        return;
      end
      want = owed_results.pop_front();
      if (got.transfer_valid !== want.transfer_valid)
        report_mismatch("transfer_valid", got.transfer_valid, want.transfer_valid);
      if (got.tx_byte !== want.tx_byte)
        report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
      if (got.select_high !== want.select_high)
        report_mismatch("select_high", got.select_high, want.select_high);
      if (got.done_res !== want.done_res)
        report_mismatch("done_res", got.done_res, want.done_res);
      if (got.response !== want.response)
        report_mismatch("response", got.response, want.response);
      if (got.timed_out !== want.timed_out)
        report_mismatch("timed_out", got.timed_out, want.timed_out);
      if (data[OutDataWidth-1:ResultWidth] !== '0)
        report_mismatch("padding", data[OutDataWidth-1:ResultWidth], '0);
    endtask
  endclass

  logic                     clk;
  logic                     rst           = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InDataWidth-1:0]   s_axis_tdata  = '0;
  logic                     s_axis_tuser  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_axis_tdata;
  logic                     cfg_valid     = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index     = '0;
  logic [CfgDataWidth-1:0]  cfg_data      = '0;

  r1_exchange_tracker tracker = new();

  int unsigned command_items = 0;
  int unsigned burst_left    = 0;
  int unsigned quiet_cycles  = 0;
  logic [15:0] stall_pat     = 16'hFFFF;
  logic [5:0]  stall_step    = '0;

  sd_spi_command_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stall pattern, reloaded whenever the 6-bit step counter wraps
  always @(posedge clk) begin
    if (stall_step == '0) begin
      stall_pat     <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      m_axis_tready <= 1'b1;
    end else begin
      stall_pat     <= {stall_pat[0], stall_pat[15:1]};
      m_axis_tready <= stall_pat[0];
    end
    stall_step <= stall_step + 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t rx_item(logic [7:0] rx);
    item_t it;
    it.operation     = OpRx;
    it.command_index = 6'($urandom);
    it.argument      = $urandom;
    it.crc_byte      = 8'($urandom);
    it.rx_byte       = rx;
    return it;
  endfunction

  function automatic int pick_delay(int lim);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 || lim > 40) return $urandom_range(0, 3);
    if (r < 9) return (lim == 0) ? $urandom_range(0, 1) : lim - 1 + $urandom_range(0, 2);
    return $urandom_range(0, lim);
  endfunction

  // valid stays high after a transfer until the next item or a gap replaces it
  task automatic send_item(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.rx_byte, it.crc_byte, it.argument, it.command_index};
    s_axis_tuser  <= it.operation;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (it.operation == OpStart || tracker.phase != PH_IDLE) command_items++;
    tracker.note_item(it);
    burst_left--;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CfgDataWidth-1:0] ready_val,
                            input logic [CfgDataWidth-1:0] resp_val);
    logic [CfgDataWidth-1:0] vals [2];
    vals[0] = ready_val;
    vals[1] = resp_val;
    for (int k = 0; k < 2; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (k == 0) ? RegReadyLimit : RegRespLimit;
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.note_config((k == 0) ? RegReadyLimit : RegRespLimit, vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // answers the card side until the command finishes or is cut short
  task automatic drive_to_idle(input int ready_wait, input int busy_polls, input int cut_after);
    int n;
    logic [7:0] rx;
    n = 0;
    while (tracker.phase != PH_IDLE && !(cut_after > 0 && n >= cut_after)) begin
      case (tracker.phase)
        PH_READY: begin
          if (ready_wait > 0) begin
            rx = 8'($urandom_range(0, 254));
            ready_wait--;
          end else begin
            rx = FillByte;
          end
        end
        PH_RESP: begin
          if (busy_polls > 0) begin
            rx = 8'h80 | 8'($urandom_range(0, 127));
            busy_polls--;
          end else begin
            rx = 8'($urandom_range(0, 127));
          end
        end
        default: rx = 8'($urandom);
      endcase
      send_item(rx_item(rx));
      n++;
    end
  endtask

  task automatic run_command(input logic [5:0] cmd, input logic [31:0] arg, input logic [7:0] crc,
                             input int ready_wait, input int busy_polls, input int cut_after);
    item_t it;
    it.operation     = OpStart;
    it.command_index = cmd;
    it.argument      = arg;
    it.crc_byte      = crc;
    it.rx_byte       = 8'($urandom);
    send_item(it);
    drive_to_idle(ready_wait, busy_polls, cut_after);
  endtask

  initial begin
    logic [CfgDataWidth-1:0] ready_plan [6];
    logic [CfgDataWidth-1:0] resp_plan [6];
    logic [CfgDataWidth-1:0] rl;
    logic [CfgDataWidth-1:0] pl;
    int unsigned budget;
    int rw;
    bit long_wait;

    ready_plan = '{10'd1, 10'd0, 10'd1023, 10'd3, 10'd0, 10'd1000};
    resp_plan  = '{10'd1, 10'd0, 10'd255, 10'h305, 10'd0, 10'd10};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // card bytes while idle are ignored
    send_item(rx_item(FillByte));
    send_item(rx_item(8'h00));
    run_command(6'h3F, 32'hFFFF_FFFF, 8'hFF, 1, 1, 0);
    // start while busy abandons the running command
    run_command(6'h00, 32'h0000_0000, 8'h00, 0, 0, 2);
    run_command(6'h2A, 32'hA5A5_5A5A, 8'h95, 0, 0, 0);

    for (int s = 0; s < 6; s++) begin
      wait_idle();
      rl = ready_plan[s];
      pl = resp_plan[s];
      if (s == 4) begin
        rl = CfgDataWidth'($urandom_range(1, 40));
        pl = CfgDataWidth'($urandom_range(1, 12));
      end
      set_limits(rl, pl);
      budget    = command_items + PhaseItems;
      long_wait = (s == 2);
      while (command_items < budget) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 3)) send_item(rx_item(8'($urandom)));
        end
        rw        = long_wait ? 1023 : pick_delay(tracker.ready_limit);
        long_wait = 1'b0;
        run_command(6'($urandom), $urandom, 8'($urandom), rw, pick_delay(tracker.resp_limit),
                    ($urandom_range(0, 11) == 0) ? $urandom_range(1, 12) : 0);
      end
      if (tracker.phase != PH_IDLE) drive_to_idle(0, 0, 0);
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
